/* hw/rtl/scsd_pkg.sv */
package scsd_pkg;

   // Field and register widths.
   localparam int PIX_W = 12;
   localparam int CFG_W = 13;
   localparam int CHAN_W = 8;
   localparam int PHASE_W = 16;
   localparam int SINE_W = 16;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 13'd512;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd512;

   // Sine table geometry; the entry count is a power of two.
   localparam int SINE_TABLE_ENTRIES = 1024;
   localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);
   localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

   // Arithmetic widths along the datapath.
   localparam int PI_H_W = 31;
   localparam logic [17:0] PI_Q16 = 18'd205887;
   localparam int SH_W = 30;
   localparam int KP_W = 48;
   localparam int CURVE_W = 23;
   localparam int K_W = 24;
   localparam int KSQ_W = 46;
   localparam int WSQ_W = 26;
   localparam int RAD_W = 48;
   localparam int ROOT_W = 24;
   localparam int DY_W = 22;
   localparam int NUM_W = DY_W + CFG_W + 8;
   localparam int DIST_W = 9;
   localparam int REM_W = ROOT_W + DIST_W + 1;
   localparam logic [DIST_W-1:0] WEIGHT_ONE = 9'd256;

   // Fixed-point constants of the table generator.
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef logic signed [SINE_W-1:0] sine_rom_type [SINE_TABLE_ENTRIES];

   // Quotient of two non-negative values by shift and subtract.
   function automatic longint shift_divide(longint num, longint den);
      longint quo;
      longint rem;
      quo = 0;
      rem = 0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
         quo = quo <<< 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'sd1;
         end
      end
      return quo;
   endfunction

   // Sine of a quarter-turn fraction in Q0.30, eight-term Taylor series.
   function automatic longint sin_quarter_q30(longint r);
      longint t;
      longint t2;
      longint term;
      longint sum;
      t = (r * HALF_PI_Q30) >>> 30;
      t2 = (t * t) >>> 30;
      term = t;
      sum = t;
      for (int n = 1; n <= 7; n++) begin
         term = shift_divide((term * t2) >>> 30, longint'((2 * n) * (2 * n + 1)));
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return (sum < 0) ? 64'sd0 : sum;
   endfunction

   // Q1.15 sine table over one full turn.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned u;
      longint unsigned quad;
      longint r;
      longint s;
      longint q;
      for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
         u = longint'(k) << (32 - SINE_IDX_W);
         quad = (u >> 30) & 64'd3;
         r = longint'(u & 64'(Q30_ONE - 1));
         if (quad[0]) begin
            r = Q30_ONE - r;
         end
         s = sin_quarter_q30(r);
         q = (s + 64'sd16384) >>> 15;
         if (q > 64'sd32767) begin
            q = 64'sd32767;
         end
         rom[k] = quad[1] ? SINE_W'(-q) : SINE_W'(q);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Item passed from the phase divider to the curve stages.
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [PIX_W-1:0]   pixel_y;
   } phase_item_type;

   // Item passed from the curve stages to the square root.
   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [DY_W-1:0]  dy;
      logic             axis;
   } span_item_type;

   // Item passed from the square root to the blend stages.
   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic [DY_W-1:0]   dy;
      logic              axis;
   } dist_item_type;

endpackage

/* hw/rtl/scsd_if.sv */
// Pixel request channel.
interface scsd_req_if;
   import scsd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// Shaded color channel.
interface scsd_rsp_if;
   import scsd_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* hw/rtl/scsd_phase_div.sv */
module scsd_phase_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [scsd_pkg::PIX_W-1:0]    in_pixel_x,
   input  logic [scsd_pkg::PIX_W-1:0]    in_pixel_y,
   input  logic [scsd_pkg::CFG_W-1:0]    divisor,
   output logic                          out_valid,
   output scsd_pkg::phase_item_type      out_item
);
   import scsd_pkg::*;

   // One quotient bit per stage: 2x has CFG_W bits, then PHASE_W zero bits follow.
   localparam int DIV_STEPS = CFG_W + PHASE_W;

   typedef struct packed {
      logic [CFG_W-1:0]   num;
      logic [CFG_W-1:0]   rem;
      logic [PHASE_W-1:0] quo;
      logic [PIX_W-1:0]   pixel_y;
   } div_stage_type;

   logic [DIV_STEPS-1:0] valid_ff;
   logic [DIV_STEPS-1:0] valid_in;
   logic [DIV_STEPS-1:0] dbit_w;
   div_stage_type        prev_w [DIV_STEPS];
   div_stage_type        stage_in [DIV_STEPS];
   div_stage_type        stage_ff [DIV_STEPS];

   assign prev_w[0] = '{num: CFG_W'({in_pixel_x, 1'b0}), rem: '0, quo: '0,
                        pixel_y: in_pixel_y};

   // Restoring division step; only the low PHASE_W quotient bits are kept.
   genvar j;
   for (j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [CFG_W:0] trial;
      logic           fits;

      if (j > 0) begin : g_link
         assign prev_w[j] = stage_ff[j-1];
      end
      if (j < CFG_W) begin : g_num
         assign dbit_w[j] = prev_w[j].num[CFG_W-1-j];
      end else begin : g_zero
         assign dbit_w[j] = 1'b0;
      end

      assign trial = {prev_w[j].rem, dbit_w[j]};
      assign fits = trial >= {1'b0, divisor};

      always_comb begin
         stage_in[j] = prev_w[j];
         stage_in[j].quo = {prev_w[j].quo[PHASE_W-2:0], fits};
         stage_in[j].rem = fits ? CFG_W'(trial - {1'b0, divisor}) : trial[CFG_W-1:0];
      end
   end

   assign valid_in = {valid_ff[DIV_STEPS-2:0], in_valid};

   // Valid bits move with the data whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_item.phase = stage_ff[DIV_STEPS-1].quo;
   assign out_item.pixel_y = stage_ff[DIV_STEPS-1].pixel_y;

   // The partial remainder of a finished division is below the divisor.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_STEPS-1] |-> (stage_ff[DIV_STEPS-1].rem < divisor))
      else $error("phase divider remainder not reduced");

endmodule

/* hw/rtl/scsd_curve.sv */
module scsd_curve (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  scsd_pkg::phase_item_type      in_item,
   input  logic [scsd_pkg::CFG_W-1:0]    frame_width,
   input  logic [scsd_pkg::CFG_W-1:0]    frame_height,
   output logic                          out_valid,
   output scsd_pkg::span_item_type       out_item
);
   import scsd_pkg::*;

   localparam int C_STAGES = 5;
   localparam int AX_W = CFG_W + 2;

   logic [C_STAGES-1:0] valid_ff;

   // Stage 0: sine and cosine table reads, pi*h product.
   logic [PHASE_W-1:0]       cos_phase;
   logic [SINE_IDX_W-1:0]    sin_idx;
   logic [SINE_IDX_W-1:0]    cos_idx;
   logic [PI_H_W-1:0]        pi_h_in;
   logic signed [SINE_W-1:0] sin_ff;
   logic signed [SINE_W-1:0] cos_ff;
   logic [PI_H_W-1:0]        pi_h_ff;
   logic [PIX_W-1:0]         y0_ff;

   assign cos_phase = in_item.phase + QUARTER_TURN;
   assign sin_idx = in_item.phase[PHASE_W-1 -: SINE_IDX_W];
   assign cos_idx = cos_phase[PHASE_W-1 -: SINE_IDX_W];
   assign pi_h_in = PI_H_W'(PI_Q16) * PI_H_W'(frame_height);

   // Stage 1: height and slope products, axis row test.
   logic signed [SH_W-1:0] sh_in;
   logic signed [KP_W-1:0] kp_in;
   logic signed [AX_W-1:0] axis_diff;
   logic                   axis_in;
   logic signed [SH_W-1:0] sh_ff;
   logic signed [KP_W-1:0] kp_ff;
   logic                   axis1_ff;
   logic [PIX_W-1:0]       y1_ff;

   assign sh_in = sin_ff * $signed({1'b0, frame_height});
   assign kp_in = cos_ff * $signed({1'b0, pi_h_ff});
   assign axis_diff = $signed({2'b00, y0_ff, 1'b0}) - $signed({2'b00, frame_height});
   assign axis_in = (axis_diff > -AX_W'(2)) && (axis_diff < AX_W'(2));

   // Stage 2: rounded curve height and slope term.
   logic signed [SH_W-1:0]    sh_round;
   logic signed [KP_W-1:0]    kp_round;
   logic signed [CURVE_W-1:0] curve_in;
   logic signed [K_W-1:0]     k_in;
   logic signed [CURVE_W-1:0] curve_ff;
   logic signed [K_W-1:0]     k_ff;
   logic                      axis2_ff;
   logic [PIX_W-1:0]          y2_ff;

   assign sh_round = sh_ff + SH_W'(256);
   assign kp_round = kp_ff + KP_W'(4194304);
   assign curve_in = CURVE_W'(sh_round >>> 9) + $signed({3'b000, frame_height, 7'b0});
   assign k_in = K_W'(kp_round >>> 23);

   // Stage 3: vertical distance and the two squares.
   logic signed [CURVE_W-1:0] dy_diff;
   logic [DY_W-1:0]           dy_in;
   logic [K_W-2:0]            k_abs;
   logic [KSQ_W-1:0]          ksq_in;
   logic [WSQ_W-1:0]          wsq_in;
   logic [DY_W-1:0]           dy_ff;
   logic [KSQ_W-1:0]          ksq_ff;
   logic [WSQ_W-1:0]          wsq_ff;
   logic                      axis3_ff;

   assign dy_diff = curve_ff - $signed({3'b000, y2_ff, 8'b0});
   assign dy_in = dy_diff[CURVE_W-1] ? DY_W'(-dy_diff) : DY_W'(dy_diff);
   assign k_abs = k_ff[K_W-1] ? (K_W-1)'(-k_ff) : (K_W-1)'(k_ff);
   assign ksq_in = KSQ_W'(k_abs) * KSQ_W'(k_abs);
   assign wsq_in = WSQ_W'(frame_width) * WSQ_W'(frame_width);

   // Stage 4: (w*256)^2 + k^2 as the radicand.
   logic [RAD_W-1:0] rad_in;

   assign rad_in = RAD_W'({wsq_ff, 16'b0}) + RAD_W'(ksq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[C_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= SINE_ROM[sin_idx];
         cos_ff <= SINE_ROM[cos_idx];
         pi_h_ff <= pi_h_in;
         y0_ff <= in_item.pixel_y;
         sh_ff <= sh_in;
         kp_ff <= kp_in;
         axis1_ff <= axis_in;
         y1_ff <= y0_ff;
         curve_ff <= curve_in;
         k_ff <= k_in;
         axis2_ff <= axis1_ff;
         y2_ff <= y1_ff;
         dy_ff <= dy_in;
         ksq_ff <= ksq_in;
         wsq_ff <= wsq_in;
         axis3_ff <= axis2_ff;
         out_item.rad <= rad_in;
         out_item.dy <= dy_ff;
         out_item.axis <= axis3_ff;
      end
   end

   assign out_valid = valid_ff[C_STAGES-1];

endmodule

/* hw/rtl/scsd_isqrt.sv */
module scsd_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  scsd_pkg::span_item_type   in_item,
   output logic                      out_valid,
   output scsd_pkg::dist_item_type   out_item
);
   import scsd_pkg::*;

   typedef struct packed {
      logic [RAD_W-1:0] v;
      logic [RAD_W-1:0] res;
      logic [DY_W-1:0]  dy;
      logic             axis;
   } isq_stage_type;

   logic [ROOT_W-1:0] valid_ff;
   isq_stage_type     prev_w [ROOT_W];
   isq_stage_type     stage_in [ROOT_W];
   isq_stage_type     stage_ff [ROOT_W];

   assign prev_w[0] = '{v: in_item.rad, res: '0, dy: in_item.dy, axis: in_item.axis};

   // One root bit per stage, from the top power of four down.
   genvar j;
   for (j = 0; j < ROOT_W; j++) begin : g_step
      localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (2 * (ROOT_W - 1 - j));
      logic [RAD_W:0] trial;
      logic           fits;

      if (j > 0) begin : g_link
         assign prev_w[j] = stage_ff[j-1];
      end

      assign trial = {1'b0, prev_w[j].res} + {1'b0, STEP_BIT};
      assign fits = {1'b0, prev_w[j].v} >= trial;

      always_comb begin
         stage_in[j] = prev_w[j];
         if (fits) begin
            stage_in[j].v = RAD_W'({1'b0, prev_w[j].v} - trial);
            stage_in[j].res = (prev_w[j].res >> 1) + STEP_BIT;
         end else begin
            stage_in[j].res = prev_w[j].res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_item.root = stage_ff[ROOT_W-1].res[ROOT_W-1:0];
   assign out_item.dy = stage_ff[ROOT_W-1].dy;
   assign out_item.axis = stage_ff[ROOT_W-1].axis;

endmodule

/* hw/rtl/scsd_blend.sv */
module scsd_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  scsd_pkg::dist_item_type       in_item,
   input  logic [scsd_pkg::CFG_W-1:0]    frame_width,
   output logic                          out_valid,
   output logic [scsd_pkg::CHAN_W-1:0]   red,
   output logic [scsd_pkg::CHAN_W-1:0]   green
);
   import scsd_pkg::*;

   // Stages: product, saturation test, DIST_W quotient bits, weight, color.
   localparam int B_STAGES = DIST_W + 4;
   localparam int PROD_W = DY_W + CFG_W;
   localparam int VG_W = DIST_W + 6;
   localparam int VR_W = DIST_W + 8;
   localparam int CP_W = VR_W + 8;
   localparam int COLOR_FRAC = 16;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] den;
      logic [DIST_W-1:0] quo;
      logic              sat;
      logic              axis;
   } quo_stage_type;

   logic [B_STAGES-1:0] valid_ff;

   // Stage 0: numerator dy * w * 256.
   logic [PROD_W-1:0] prod_in;
   logic [NUM_W-1:0]  num_ff;
   logic [ROOT_W-1:0] den_ff;
   logic              axis0_ff;

   assign prod_in = PROD_W'(in_item.dy) * PROD_W'(frame_width);

   // Stage 1: distances of 512 or more saturate the weight.
   logic              sat_in;
   quo_stage_type     head_ff;

   assign sat_in = num_ff >= NUM_W'({den_ff, 9'b0});

   // Stages 2 onward: restoring division for the low quotient bits.
   quo_stage_type prev_w [DIST_W];
   quo_stage_type stage_in [DIST_W];
   quo_stage_type stage_ff [DIST_W];

   assign prev_w[0] = head_ff;

   genvar s;
   for (s = 0; s < DIST_W; s++) begin : g_step
      localparam int SHIFT = DIST_W - 1 - s;
      logic [REM_W-1:0] part;
      logic             fits;

      if (s > 0) begin : g_link
         assign prev_w[s] = stage_ff[s-1];
      end

      assign part = REM_W'(prev_w[s].den) << SHIFT;
      assign fits = prev_w[s].rem >= part;

      always_comb begin
         stage_in[s] = prev_w[s];
         stage_in[s].quo[SHIFT] = fits;
         if (fits) begin
            stage_in[s].rem = prev_w[s].rem - part;
         end
      end
   end

   // Weight stage: distance minus one, clamped to 0..1 in Q1.8.
   quo_stage_type     last_w;
   logic [DIST_W-1:0] wt_in;
   logic [DIST_W-1:0] wt_ff;
   logic              axis_wt_ff;

   assign last_w = stage_ff[DIST_W-1];

   always_comb begin
      priority if (last_w.sat) begin
         wt_in = WEIGHT_ONE;
      end else if (last_w.quo <= WEIGHT_ONE) begin
         wt_in = '0;
      end else begin
         wt_in = last_w.quo - WEIGHT_ONE;
      end
   end

   // Color stage: blend red over the background and round to 8 bits.
   logic [VG_W-1:0] vg;
   logic [VR_W-1:0] vr;
   logic [CP_W-1:0] red_prod;
   logic [CP_W-1:0] green_prod;

   assign vg = axis_wt_ff ? {wt_ff, 6'b0} : '0;
   assign vr = {WEIGHT_ONE - wt_ff, 8'b0} + VR_W'(vg);
   assign red_prod = {vr, 8'b0} - CP_W'(vr) + CP_W'(32768);
   assign green_prod = CP_W'({vg, 8'b0}) - CP_W'(vg) + CP_W'(32768);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[B_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= {prod_in, 8'b0};
         den_ff <= in_item.root;
         axis0_ff <= in_item.axis;
         head_ff <= '{rem: num_ff[REM_W-1:0], den: den_ff, quo: '0, sat: sat_in,
                      axis: axis0_ff};
         stage_ff <= stage_in;
         wt_ff <= wt_in;
         axis_wt_ff <= last_w.axis;
         red <= red_prod[COLOR_FRAC+CHAN_W-1:COLOR_FRAC];
         green <= green_prod[COLOR_FRAC+CHAN_W-1:COLOR_FRAC];
      end
   end

   assign out_valid = valid_ff[B_STAGES-1];

   // The blend weight never exceeds one.
   a_weight_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[B_STAGES-2] |-> (wt_ff <= WEIGHT_ONE))
      else $error("blend weight above one");

   // Red always carries at least the background level.
   a_red_covers_green: assert property (@(posedge clock) disable iff (reset)
      valid_ff[B_STAGES-1] |-> (red >= green))
      else $error("red below background level");

endmodule

/* hw/rtl/sine_curve_distance_shader_top.sv */
// Channel   Direction  Payload                        Handshake
// req_chan  in         pixel_x[11:0], pixel_y[11:0]   valid/ready
// rsp_chan  out        red[7:0], green[7:0], blue[7:0] valid/ready
// csr       in         csr_index[0], csr_wdata[12:0]  csr_write_en
//
// One pixel is accepted per cycle while the pipeline advances; each result passes
// through 29 phase divider steps, 5 curve stages, 24 square root steps and
// 13 blend stages, the last of which is the output register.
// Reset is synchronous and clears all valid bits and sets both frame sizes to 512.
// The whole pipeline holds when a result waits and rsp_chan.ready is low;
// req_chan.ready follows that same advance condition.
module sine_curve_distance_shader_top (
   input  logic                              clock,
   input  logic                              reset,
   scsd_req_if.sink                          req_chan,
   scsd_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [scsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scsd_pkg::CFG_W-1:0]        csr_wdata
);
   import scsd_pkg::*;

   logic [CFG_W-1:0] frame_width_ff;
   logic [CFG_W-1:0] frame_height_ff;
   logic [CFG_W-1:0] width_eff;
   logic             adv;
   logic             phase_valid;
   phase_item_type   phase_item;
   logic             span_valid;
   span_item_type    span_item;
   logic             dist_valid;
   dist_item_type    dist_item;
   logic             pix_valid;
   logic [CHAN_W-1:0] pix_red;
   logic [CHAN_W-1:0] pix_green;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: frame_width_ff <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero width behaves as one.
   assign width_eff = (frame_width_ff == '0) ? CFG_W'(1) : frame_width_ff;

   // The pipeline moves unless the output register holds an item not yet taken.
   assign adv = !pix_valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   scsd_phase_div u_phase_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_chan.valid),
      .in_pixel_x (req_chan.pixel_x),
      .in_pixel_y (req_chan.pixel_y),
      .divisor    (width_eff),
      .out_valid  (phase_valid),
      .out_item   (phase_item)
   );

   scsd_curve u_curve (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (phase_valid),
      .in_item      (phase_item),
      .frame_width  (width_eff),
      .frame_height (frame_height_ff),
      .out_valid    (span_valid),
      .out_item     (span_item)
   );

   scsd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (span_valid),
      .in_item   (span_item),
      .out_valid (dist_valid),
      .out_item  (dist_item)
   );

   scsd_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (dist_valid),
      .in_item     (dist_item),
      .frame_width (width_eff),
      .out_valid   (pix_valid),
      .red         (pix_red),
      .green       (pix_green)
   );

   assign rsp_chan.valid = pix_valid;
   assign rsp_chan.red = pix_red;
   assign rsp_chan.green = pix_green;
   assign rsp_chan.blue = pix_green;

   // Reset leaves both frame sizes at their defaults.
   a_reset_sizes: assert property (@(posedge clock)
      reset |=> (frame_width_ff == FRAME_WIDTH_RESET) &&
                (frame_height_ff == FRAME_HEIGHT_RESET))
      else $error("frame sizes not restored by reset");

endmodule
